// File: src/dmps_pkg.sv
package dmps_pkg;

	// Default depth of the previous-row store (largest diamond half).
	localparam int MAX_HALF_ROWS_DEF = 128;

	// Item field widths.
	localparam int CELL_W = 16;
	localparam int SUM_W  = 24;

	// Saturation ceiling of a path sum.
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Configuration port layout: one 32-bit register per word.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int HALF_W  = 8;

	// Register index, taken from the word address paddr[PADDR_W-1:2].
	localparam logic [PADDR_W-3:0] REG_HALF_ROWS = '0;

	// Reset value of half_rows.
	localparam logic [HALF_W-1:0] HALF_ROWS_RST = 8'd1;

endpackage

// File: src/diamond_max_path_sum_unit.sv
// Diamond maximum path sum.
// Cells of a diamond (rows of 1, 2, .. N, .. 2, 1 cells) stream in on the
// slave channel (s_tvalid/s_tready/s_tdata), one unsigned cell value per
// item, in row-major order. After the final single cell the largest
// top-to-bottom path sum leaves on the master channel as one item, and the
// next cell starts a new diamond.
// N is the half_rows register on the APB port (word address 0); writing it
// abandons a diamond in progress. A zero setting acts as 1, values above
// MAX_HALF_ROWS are clipped to it.
// Throughput is one cell per clock while no result is stalled: each cell needs
// one add and one max against two neighbor registers, which the previous-row
// memory refills through a read issued two columns ahead.
// Latency: the result item is valid in the cycle after the final cell is
// accepted.
// Reset restarts at the top of a diamond with half_rows = 1 and an empty
// result register. When the receiver stalls with a result waiting, s_tready
// drops until the held item is taken; a result taken in the same cycle as a
// new cell keeps the input streaming at one cell per clock.
module diamond_max_path_sum_unit #(
	parameter int MAX_HALF_ROWS = dmps_pkg::MAX_HALF_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dmps_pkg::PADDR_W-1:0] paddr,
	input  logic [dmps_pkg::PDATA_W-1:0] pwdata,
	output logic [dmps_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// Cell input
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // [15:0] cell_value
	// Result output
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata   // [23:0] best_sum
);

	localparam int COL_W  = (MAX_HALF_ROWS > 1) ? $clog2(MAX_HALF_ROWS) : 1;
	localparam int ROW_W  = $clog2(2 * MAX_HALF_ROWS);
	localparam int CALC_W = ROW_W + 9;
	localparam int SUM_W  = dmps_pkg::SUM_W;
	localparam logic [CALC_W-1:0] MAX_N = CALC_W'(MAX_HALF_ROWS);

	// Registers
	logic [dmps_pkg::HALF_W-1:0] half_rows_q;
	logic [ROW_W-1:0]            row_q;
	logic [COL_W-1:0]            col_q;
	logic [SUM_W-1:0]            hold_q;
	logic [SUM_W-1:0]            a_q;
	logic [SUM_W-1:0]            b_reg_q;
	logic                        b_mem_q;
	logic [SUM_W-1:0]            mem_rd_q;
	logic [SUM_W-1:0]            first0_q;
	logic [SUM_W-1:0]            first1_q;
	logic                        out_valid_q;
	logic [SUM_W-1:0]            out_data_q;
	logic [SUM_W-1:0]            row_mem [MAX_HALF_ROWS];

	// Combinational signals
	logic              cfg_wr;
	logic              cfg_hit;
	logic              in_acc;
	logic [CALC_W-1:0] n_raw;
	logic [CALC_W-1:0] n_eff;
	logic [CALC_W-1:0] r_w;
	logic [CALC_W-1:0] c_w;
	logic [CALC_W-1:0] row_len;
	logic [CALC_W-1:0] rd_sum;
	logic [COL_W-1:0]  rd_addr;
	logic              grow;
	logic              row_last;
	logic              diamond_last;
	logic [SUM_W-1:0]  b_cur;
	logic [SUM_W-1:0]  pred;
	logic [SUM_W:0]    sum;
	logic [SUM_W-1:0]  best;

	// APB decode; writes complete in the access cycle.
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[dmps_pkg::PADDR_W-1:2] == dmps_pkg::REG_HALF_ROWS);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
	assign prdata  = cfg_hit ? dmps_pkg::PDATA_W'(half_rows_q) : '0;

	// Handshakes: the result register parts the two sides.
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Effective half size and position within the diamond.
	always_comb begin
		n_raw = CALC_W'(half_rows_q);
		if (n_raw == '0) begin
			n_eff = CALC_W'(1);
		end else if (n_raw > MAX_N) begin
			n_eff = MAX_N;
		end else begin
			n_eff = n_raw;
		end
		r_w     = CALC_W'(row_q);
		c_w     = CALC_W'(col_q);
		grow    = (r_w < n_eff);
		row_len = grow ? (r_w + CALC_W'(1)) : ((n_eff << 1) - CALC_W'(1) - r_w);
		row_last     = ((c_w + CALC_W'(1)) >= row_len);
		diamond_last = (r_w == ((n_eff << 1) - CALC_W'(2))) && row_last;
		rd_sum  = c_w + CALC_W'(2);
		rd_addr = rd_sum[COL_W-1:0];
	end

	// Best predecessor and saturating sum for the current cell.
	always_comb begin
		b_cur = b_mem_q ? mem_rd_q : b_reg_q;
		pred  = '0;
		if (row_q == '0) begin
			pred = '0;
		end else if (grow) begin
			if (col_q != '0) begin
				pred = hold_q;
			end
			if ((c_w < r_w) && (a_q > pred)) begin
				pred = a_q;
			end
		end else begin
			pred = (a_q > b_cur) ? a_q : b_cur;
		end
		sum  = {1'b0, pred} + (SUM_W+1)'(s_tdata);
		best = sum[SUM_W] ? dmps_pkg::SUM_MAX : sum[SUM_W-1:0];
	end

	// Position counters and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_rows_q <= dmps_pkg::HALF_ROWS_RST;
			row_q       <= '0;
			col_q       <= '0;
			hold_q      <= '0;
		end else if (cfg_wr) begin
			half_rows_q <= pwdata[dmps_pkg::HALF_W-1:0];
			row_q       <= '0;
			col_q       <= '0;
			hold_q      <= '0;
		end else if (in_acc) begin
			hold_q <= row_last ? '0 : a_q;
			if (diamond_last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (!row_last) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	// Neighbor registers: old[c] in a_q, old[c+1] in b_reg_q or the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_reg_q  <= '0;
			b_mem_q  <= 1'b0;
			first0_q <= '0;
			first1_q <= '0;
		end else if (in_acc) begin
			if (col_q == COL_W'(0)) begin
				first0_q <= best;
			end
			if (col_q == COL_W'(1)) begin
				first1_q <= best;
			end
			if (row_last) begin
				a_q     <= (col_q == COL_W'(0)) ? best : first0_q;
				b_reg_q <= (col_q == COL_W'(1)) ? best : first1_q;
				b_mem_q <= 1'b0;
			end else begin
				a_q     <= b_cur;
				b_mem_q <= 1'b1;
			end
		end
	end

	// Previous-row memory: write at the current column, read two ahead.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_mem[col_q] <= best;
		end
		if (in_acc && !row_last) begin
			mem_rd_q <= row_mem[rd_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && diamond_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && diamond_last) begin
			out_data_q <= best;
		end
	end

endmodule

// File: src/dmps_checker.sv
module dmps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A clock edge under reset leaves the result register empty.
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A new result only follows an accepted cell.
	a_rise_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without a cell");

	// Back-to-back results need a cell accepted in between.
	a_next_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && $past(m_tvalid && m_tready) |-> $past(s_tvalid && s_tready))
		else $error("repeated result");

	// A full, stalled result register blocks new cells.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("cell taken while result stalled");

endmodule

bind diamond_max_path_sum_unit dmps_checker u_dmps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
